@@ src/assert_macros.svh @@
// Concurrent assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold in any cycle where trig holds
`define ASSERT_IMPLIES(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("implication check failed");

// cond must hold dly cycles after trig
`define ASSERT_DELAYED(label, clk, rst, trig, dly, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> ##dly (cond)) \
    else $error("delayed check failed");

`endif

@@ src/dg3d_pkg.sv @@
package dg3d_pkg;

  typedef struct packed {
    logic               use_item_mean;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic signed [31:0] mean_z;
  } item_t;

  typedef struct packed {
    logic [31:0] density;
    logic        saturated;
  } result_t;

  // register map
  localparam logic [2:0] REG_SCALE     = 3'd0;
  localparam logic [2:0] REG_INV_VAR_X = 3'd1;
  localparam logic [2:0] REG_INV_VAR_Y = 3'd2;
  localparam logic [2:0] REG_INV_VAR_Z = 3'd3;
  localparam logic [2:0] REG_CENTER_X  = 3'd4;
  localparam logic [2:0] REG_CENTER_Y  = 3'd5;
  localparam logic [2:0] REG_CENTER_Z  = 3'd6;

  // 1.0 in the register format
  localparam logic [31:0] REG_ONE = 32'h0001_0000;

  // log2(e) and ln(2) in Q30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;

endpackage

@@ src/diag_gaussian3_density_core.sv @@
// An accepted item moves through valid bits v1 to v8, then raises done with its result.
// Throughput: one item per cycle; busy is low whenever rst is low, nine items in flight.
// The result strobe lasts one cycle; the receiver cannot stall, so nothing is held back.
// Reset (rst, synchronous, active high) clears all stage valid bits and loads the
// registers with scale = inv_var = 1.0 and center = 0; busy is high during reset.
`include "assert_macros.svh"

module diag_gaussian3_density_core #(
  parameter int FRAC_BITS       = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  // item channel
  input  logic             start,
  output logic             busy,
  input  dg3d_pkg::item_t  item,
  // result channel
  output logic             done,
  output dg3d_pkg::result_t result,
  // register write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import dg3d_pkg::*;

  // Pipeline:
  //   s1 mean select, diff, magnitude     s2 diff^2 (32x32)
  //   s3 inv_var * diff^2 as two 32x32 partial products per axis
  //   s4 merge partials, >>(2F+1), clamp at 32.0    s5 sum of terms, range test
  //   s6 * log2(e)    s7 split int/frac, 2^-frac table    s8 scale * table
  //   s9 >> (30+k), output register
  localparam int TW    = FRAC_BITS + 6;          // term, holds the 32.0 clamp
  localparam int AW    = FRAC_BITS + 7;          // sum of three terms
  localparam int BW    = FRAC_BITS + 6;          // a*log2(e) while a < 32.0
  localparam int JW    = $clog2(EXP_TABLE_DEPTH);
  localparam int SHR   = 2 * FRAC_BITS + 1;      // square and the 0.5 factor
  localparam int OVF   = 3 * FRAC_BITS + 6;      // product bits at or above -> clamp
  localparam int LAT   = 9;
  localparam logic [AW-1:0] LIMIT = AW'(1) << (FRAC_BITS + 5);

  // ---------------------------------------------------------------- registers
  logic [31:0]        scale;
  logic [31:0]        inv_var [3];
  logic signed [31:0] center  [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= REG_ONE;
      inv_var[0] <= REG_ONE;
      inv_var[1] <= REG_ONE;
      inv_var[2] <= REG_ONE;
      center[0]  <= '0;
      center[1]  <= '0;
      center[2]  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCALE:     scale      <= cfg_data;
        REG_INV_VAR_X: inv_var[0] <= cfg_data;
        REG_INV_VAR_Y: inv_var[1] <= cfg_data;
        REG_INV_VAR_Z: inv_var[2] <= cfg_data;
        REG_CENTER_X:  center[0]  <= cfg_data;
        REG_CENTER_Y:  center[1]  <= cfg_data;
        REG_CENTER_Z:  center[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------------- 2^-j/D table
  // Alternating series for exp(-y), y = (j/D)*ln2, each term truncated.
  logic [30:0] pow2_tab [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [63:0] X   = (64'(g) << 30) / EXP_TABLE_DEPTH;
    localparam logic [63:0] Y   = (X * LN2_Q30) >> 30;
    localparam logic [63:0] T1  = ((ONE_Q30 * Y) >> 30) / 1;
    localparam logic [63:0] T2  = ((T1 * Y) >> 30) / 2;
    localparam logic [63:0] T3  = ((T2 * Y) >> 30) / 3;
    localparam logic [63:0] T4  = ((T3 * Y) >> 30) / 4;
    localparam logic [63:0] T5  = ((T4 * Y) >> 30) / 5;
    localparam logic [63:0] T6  = ((T5 * Y) >> 30) / 6;
    localparam logic [63:0] T7  = ((T6 * Y) >> 30) / 7;
    localparam logic [63:0] T8  = ((T7 * Y) >> 30) / 8;
    localparam logic [63:0] T9  = ((T8 * Y) >> 30) / 9;
    localparam logic [63:0] T10 = ((T9 * Y) >> 30) / 10;
    localparam logic [63:0] T11 = ((T10 * Y) >> 30) / 11;
    localparam logic [63:0] T12 = ((T11 * Y) >> 30) / 12;
    localparam logic [63:0] T13 = ((T12 * Y) >> 30) / 13;
    localparam logic [63:0] T14 = ((T13 * Y) >> 30) / 14;
    localparam logic [63:0] T15 = ((T14 * Y) >> 30) / 15;
    localparam logic [63:0] T16 = ((T15 * Y) >> 30) / 16;
    localparam logic [63:0] T17 = ((T16 * Y) >> 30) / 17;
    localparam logic [63:0] T18 = ((T17 * Y) >> 30) / 18;
    localparam logic [63:0] T19 = ((T18 * Y) >> 30) / 19;
    localparam logic [63:0] T20 = ((T19 * Y) >> 30) / 20;
    localparam logic [63:0] S   = ONE_Q30 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9
                                  + T10 - T11 + T12 - T13 + T14 - T15 + T16 - T17
                                  + T18 - T19 + T20;
    assign pow2_tab[g] = S[30:0];
  end

  // ------------------------------------------------------------ valid chain
  logic accept;
  logic v1, v2, v3, v4, v5, v6, v7, v8;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, done} <= '0;
    end else begin
      {v1, v2, v3, v4, v5, v6, v7, v8, done} <= {accept, v1, v2, v3, v4, v5, v6, v7, v8};
    end
  end

  // ------------------------------------------------------------- s1: |p - m|
  logic signed [31:0] pt   [3];
  logic signed [31:0] mu   [3];
  logic [31:0]        mag_next [3];
  logic [31:0]        mag  [3];
  logic [63:0]        sq   [3];
  logic [63:0]        plo  [3];
  logic [63:0]        phi  [3];
  logic [TW-1:0]      term [3];

  always_comb begin
    pt[0] = item.point_x;
    pt[1] = item.point_y;
    pt[2] = item.point_z;
    mu[0] = item.use_item_mean ? item.mean_x : center[0];
    mu[1] = item.use_item_mean ? item.mean_y : center[1];
    mu[2] = item.use_item_mean ? item.mean_z : center[2];
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [32:0] diff;
    logic [32:0]        absd;
    logic [63:0]        sq_next;
    logic [63:0]        plo_next, phi_next;
    logic [63:0]        mid;
    logic [95:0]        prod;
    logic [TW-1:0]      term_next;

    assign diff          = 33'(pt[i]) - 33'(mu[i]);
    assign absd          = diff[32] ? (33'd0 - diff) : diff;
    assign mag_next[i]   = absd[31:0];

    // s2: square
    assign sq_next  = 64'(mag[i]) * 64'(mag[i]);
    // s3: partial products against inv_var
    assign plo_next = 64'(inv_var[i]) * 64'(sq[i][31:0]);
    assign phi_next = 64'(inv_var[i]) * 64'(sq[i][63:32]);
    // s4: merge, drop 2F+1 bits, clamp at 32.0
    assign mid  = 64'(plo[i][63:32]) + phi[i];
    assign prod = {mid, plo[i][31:0]};
    assign term_next = (|prod[95:OVF]) ? TW'(LIMIT) : TW'(prod[SHR +: FRAC_BITS + 5]);

    always_ff @(posedge clk) begin
      sq[i]   <= sq_next;
      plo[i]  <= plo_next;
      phi[i]  <= phi_next;
      term[i] <= term_next;
    end
  end

  always_ff @(posedge clk) begin
    mag <= mag_next;
  end

  // ------------------------------------------------- s5: exponent argument
  logic [AW-1:0] a_next, a5;
  logic          big5;

  assign a_next = AW'(term[0]) + AW'(term[1]) + AW'(term[2]);

  always_ff @(posedge clk) begin
    a5   <= a_next;
    big5 <= (a_next >= LIMIT);
  end

  // ----------------------------------------------------- s6: * log2(e)
  logic [AW+30:0] bprod;
  logic [BW-1:0]  b6;
  logic           big6;

  assign bprod = (AW+31)'(a5) * (AW+31)'(LOG2E_Q30);

  always_ff @(posedge clk) begin
    b6   <= bprod[30 +: BW];
    big6 <= big5;
  end

  // ------------------------------------- s7: integer shift and table lookup
  logic [FRAC_BITS+JW-1:0] jprod;
  logic [JW-1:0]           j_next;
  logic [30:0]             entry7;
  logic [5:0]              k7;
  logic                    big7;

  assign jprod  = (FRAC_BITS+JW)'(b6[FRAC_BITS-1:0]) * (FRAC_BITS+JW)'(EXP_TABLE_DEPTH);
  assign j_next = jprod[FRAC_BITS +: JW];

  always_ff @(posedge clk) begin
    entry7 <= pow2_tab[j_next];
    k7     <= b6[FRAC_BITS +: 6];
    big7   <= big6;
  end

  // ----------------------------------------------------- s8: scale * 2^-f
  logic [62:0] prod8;
  logic [5:0]  k8;
  logic        big8;

  always_ff @(posedge clk) begin
    prod8 <= 63'(scale) * 63'(entry7);
    k8    <= k7;
    big8  <= big7;
  end

  // --------------------------------------- s9: >> (30+k), clamp, register out
  // shifts of 63 or more come out zero on their own
  logic [6:0]  sh;
  logic [62:0] shifted;
  logic        ovf;
  result_t     result_next;

  assign sh      = 7'd30 + 7'(k8);
  assign shifted = prod8 >> sh;
  assign ovf     = |shifted[62:32];

  always_comb begin
    if (big8) begin
      result_next.density   = '0;
      result_next.saturated = 1'b0;
    end else if (ovf) begin
      result_next.density   = '1;
      result_next.saturated = 1'b1;
    end else begin
      result_next.density   = shifted[31:0];
      result_next.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // ------------------------------------------------------------ assertions
  // each accepted item yields its strobe a fixed latency later
  `ASSERT_DELAYED(a_latency, clk, rst, accept, LAT, done)
  // and no strobe comes without an item behind it
  `ASSERT_IMPLIES(a_no_spurious, clk, rst, done, $past(accept, LAT))
  // density never exceeds scale, so the clamp cannot fire
  `ASSERT_IMPLIES(a_no_sat, clk, rst, done, !result.saturated)
  // an out-of-range argument reaches the output as zero
  `ASSERT_DELAYED(a_big_zero, clk, rst, v5 && big5, 4, done && result.density == '0)

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dg3d_pkg::*;

  // latency of the block's pipeline, used to pad the final drain
  localparam int PIPE_LATENCY = 9;
  // cycles with no item, result or register write before we give up
  localparam int STALL_LIMIT  = 2000;
  localparam int BLOCK_ITEMS  = 71;

  // fixed-point constants for the density predictor
  localparam int              FRAC       = 16;
  localparam int              TAB_DEPTH  = 256;
  localparam longint unsigned FRAC_MASK  = (64'd1 << FRAC) - 1;
  localparam longint unsigned ARG_CAP    = 64'd32 << FRAC;
  localparam longint unsigned LOG2E_FIX  = 64'd1549082005;
  localparam longint unsigned LN2_FIX    = 64'd744261118;
  localparam longint unsigned ONE_FIX    = 64'd1 << 30;
  localparam longint unsigned DENS_MAX   = 64'hFFFF_FFFF;

  // index past the register map; writes there must be dropped
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        done;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  diag_gaussian3_density_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the register file, kept in step with accepted writes
  // ---------------------------------------------------------------------------
  logic [31:0]     scale_q;
  logic [31:0]     inv_var_q [3];
  logic [31:0]     center_q [3];

  // 2^(-j/256) in Q30, built from the same truncated series the block uses
  longint unsigned pow2_q30 [TAB_DEPTH];

  result_t         pending_density [$];

  int              fail_count    = 0;
  int              items_taken   = 0;
  int              directed_cnt  = 0;
  int              results_seen  = 0;
  int              nonzero_seen  = 0;
  int              writes_taken  = 0;
  int              stall_cycles  = 0;
  int              gap_pct       = 0;

  function automatic void build_pow2_table();
    longint unsigned x, y, acc, t;
    int              jj, n;
    for (jj = 0; jj < TAB_DEPTH; jj++) begin
      x   = (64'(jj) << 30) / TAB_DEPTH;
      y   = (x * LN2_FIX) >> 30;
      acc = ONE_FIX;
      t   = ONE_FIX;
      // alternating series of exp(-y), each term truncated
      for (n = 1; n <= 20; n++) begin
        t = ((t * y) >> 30) / 64'(n);
        if (n % 2) acc = acc - t;
        else acc = acc + t;
      end
      pow2_q30[jj] = acc;
    end
  endfunction

  // floor(inv * diff^2 / 2^33), clipped at 32.0
  function automatic longint unsigned half_weighted_sq(logic [31:0] inv, logic [31:0] p,
                                                       logic [31:0] m);
    longint          dif;
    longint unsigned mag, sq;
    logic [127:0]    prod;
    dif  = longint'($signed(p)) - longint'($signed(m));
    mag  = (dif < 0) ? -dif : dif;
    sq   = mag * mag;
    prod = {96'b0, inv} * {64'b0, sq};
    prod = prod >> (2 * FRAC + 1);
    return (prod > ARG_CAP) ? ARG_CAP : prod[63:0];
  endfunction

  function automatic result_t predict_density(item_t it);
    logic [31:0]     mx, my, mz;
    longint unsigned a, b, k, j, dens;
    result_t         r;
    mx = it.use_item_mean ? it.mean_x : center_q[0];
    my = it.use_item_mean ? it.mean_y : center_q[1];
    mz = it.use_item_mean ? it.mean_z : center_q[2];
    a  = half_weighted_sq(inv_var_q[0], it.point_x, mx)
       + half_weighted_sq(inv_var_q[1], it.point_y, my)
       + half_weighted_sq(inv_var_q[2], it.point_z, mz);
    dens        = 0;
    r.saturated = 1'b0;
    // large argument: exp underflows to zero outright
    if (a < ARG_CAP) begin
      // exp(-a) = 2^-(a*log2 e): integer part shifts, fraction picks the entry
      b = (a * LOG2E_FIX) >> 30;
      k = b >> FRAC;
      j = ((b & FRAC_MASK) * TAB_DEPTH) >> FRAC;
      if (j >= TAB_DEPTH) j = TAB_DEPTH - 1;
      if (30 + k < 64) dens = ({32'b0, scale_q} * pow2_q30[j]) >> (30 + k);
      if (dens > DENS_MAX) begin
        dens        = DENS_MAX;
        r.saturated = 1'b1;
      end
    end
    r.density = dens[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: results cannot be held off, so every done is taken
  // ---------------------------------------------------------------------------
  result_t oldest;

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (result.density != 0) nonzero_seen++;
      if (pending_density.size() == 0) begin
        fail_count++;
        $error("unexpected result: density %h saturated %b", result.density,
               result.saturated);
      end else begin
        oldest = pending_density.pop_front();
        if (result.density !== oldest.density) begin
          fail_count++;
          $error("density: expected %h, got %h", oldest.density, result.density);
        end
        if (result.saturated !== oldest.saturated) begin
          fail_count++;
          $error("saturated: expected %b, got %b", oldest.saturated, result.saturated);
        end
      end
    end
  end

  // watchdog: any accepted item, result or write counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item and register drivers
  // ---------------------------------------------------------------------------

  // Start stays high from one item to the next unless a gap is rolled; the
  // expectation goes in at the edge that takes the item.
  task automatic push_item(item_t it, bit typed, result_t want);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items_taken++;
    pending_density.push_back(typed ? want : predict_density(it));
  endtask

  // drop start and let the pipe empty before touching registers
  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk); while (pending_density.size() != 0);
  endtask

  // caller lowers cfg_valid once the batch of writes is over
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    writes_taken++;
    case (idx)
      REG_SCALE:     scale_q      = val;
      REG_INV_VAR_X: inv_var_q[0] = val;
      REG_INV_VAR_Y: inv_var_q[1] = val;
      REG_INV_VAR_Z: inv_var_q[2] = val;
      REG_CENTER_X:  center_q[0]  = val;
      REG_CENTER_Y:  center_q[1]  = val;
      REG_CENTER_Z:  center_q[2]  = val;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------

  // Offset from the mean sized so inv * d^2 stays around or below 2^54, which
  // keeps most terms under the 32.0 cutoff and some right at its edge.
  function automatic logic [31:0] near_coord(logic [31:0] ctr, logic [31:0] inv);
    int          nb, lim, lb, bi;
    logic [31:0] d;
    nb = 0;
    for (bi = 0; bi < 32; bi++) if (inv[bi]) nb = bi + 1;
    lim = (54 - nb) / 2;
    if (lim > 30) lim = 30;
    lb = $urandom_range(lim);
    d  = $urandom & ((32'd1 << lb) - 1);
    return $urandom_range(1) ? ctr + d : ctr - d;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.use_item_mean = 1'($urandom_range(1));
    it.point_x       = $urandom;
    it.point_y       = $urandom;
    it.point_z       = $urandom;
    it.mean_x        = $urandom;
    it.mean_y        = $urandom;
    it.mean_z        = $urandom;
    // about one in seven stays fully random: mostly far tails, density zero
    if ($urandom_range(99) < 15) return it;
    it.point_x = near_coord(it.use_item_mean ? it.mean_x : center_q[0], inv_var_q[0]);
    it.point_y = near_coord(it.use_item_mean ? it.mean_y : center_q[1], inv_var_q[1]);
    it.point_z = near_coord(it.use_item_mean ? it.mean_z : center_q[2], inv_var_q[2]);
    return it;
  endfunction

  function automatic logic [31:0] pick_reg_value(logic [2:0] idx);
    int roll;
    roll = $urandom_range(9);
    case (idx)
      REG_SCALE: begin
        if (roll == 0) return '1;
        if (roll == 1) return REG_ONE;
        if (roll == 2) return 32'd1;
        return $urandom >> $urandom_range(16);
      end
      REG_INV_VAR_X, REG_INV_VAR_Y, REG_INV_VAR_Z: begin
        if (roll == 0) return '1;
        if (roll == 1) return '0;
        return $urandom >> $urandom_range(31);
      end
      default: begin
        if (roll < 2) return '0;
        if (roll == 2) return 32'h8000_0000;
        if (roll == 3) return 32'h7FFF_FFFF;
        return $urandom;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan: register writes and points, walked in order
  // ---------------------------------------------------------------------------
  typedef enum bit {ROW_POINT, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [31:0] data;
    item_t       it;
    bit          typed;
    result_t     want;
  } stim_row_t;

  stim_row_t plan [$];

  function automatic void add_write(logic [2:0] idx, logic [31:0] data);
    stim_row_t row;
    row      = '{kind: ROW_WRITE, idx: idx, data: data, it: '0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  // want is only used when typed is set; saturated is always expected low
  function automatic void add_point(logic use_mean, logic [31:0] px, logic [31:0] py,
                                    logic [31:0] pz, logic [31:0] mx, logic [31:0] my,
                                    logic [31:0] mz, bit typed, logic [31:0] want);
    stim_row_t row;
    row.kind  = ROW_POINT;
    row.idx   = '0;
    row.data  = '0;
    row.it    = '{use_mean, px, py, pz, mx, my, mz};
    row.typed = typed;
    row.want  = '{want, 1'b0};
    plan.push_back(row);
  endfunction

  initial begin
    bit cfg_driving;
    int ph, blk, r;

    build_pow2_table();
    scale_q   = REG_ONE;
    inv_var_q = '{REG_ONE, REG_ONE, REG_ONE};
    center_q  = '{32'd0, 32'd0, 32'd0};

    // reset state: scale 1.0, unit inverse variances, centers at zero
    add_point(1'b0, 0, 0, 0, 0, 0, 0, 1, REG_ONE);
    // stored center in use, item mean fields are don't-care
    add_point(1'b0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, '1, 1, REG_ONE);
    // item mean equal to the point at both ends of the range
    add_point(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, REG_ONE);
    add_point(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, REG_ONE);
    // widest difference, 33 bits
    add_point(1'b1, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 1, 32'd0);
    add_point(1'b0, 32'h8000_0000, 0, 0, 0, 0, 0, 1, 32'd0);
    // one term exactly at 32.0, then with the point one lsb lower
    add_point(1'b0, 32'h0008_0000, 0, 0, 0, 0, 0, 1, 32'd0);
    add_point(1'b0, 32'h0007_FFFF, 0, 0, 0, 0, 0, 0, 32'd0);
    add_point(1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 0, 0, 0, 0, 32'd0);
    add_point(1'b1, 0, 0, '1, 0, 0, 0, 0, 32'd0);
    // each term 12.5, sum past the cutoff
    add_point(1'b0, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 0, 0, 0, 1, 32'd0);
    add_point(1'b1, 32'h0004_0000, 32'hFFFC_0000, 32'h0004_0000, 0, 0, 0, 0, 32'd0);
    // largest scale: exp(0) keeps it whole, no clamp
    add_write(REG_SCALE, '1);
    add_point(1'b0, 0, 0, 0, 0, 0, 0, 1, '1);
    // zero inverse variance flattens every axis
    add_write(REG_INV_VAR_X, '0);
    add_write(REG_INV_VAR_Y, '0);
    add_write(REG_INV_VAR_Z, '0);
    add_point(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 0, 0, 0, 1, '1);
    // unmapped index must not disturb anything
    add_write(REG_UNMAPPED, '0);
    add_point(1'b0, 0, 0, 0, 0, 0, 0, 1, '1);
    // max inverse variance on x with centers at the ends of the range
    add_write(REG_INV_VAR_X, '1);
    add_write(REG_CENTER_X, 32'h7FFF_FFFF);
    add_write(REG_CENTER_Y, 32'h8000_0000);
    add_write(REG_CENTER_Z, 32'h7FFF_FFFF);
    add_point(1'b0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1, '1);
    add_point(1'b0, 32'h7FFF_FFFE, 0, 0, 0, 0, 0, 1, '1);
    add_point(1'b0, 32'h7FFF_FF00, 0, 0, 0, 0, 0, 0, 32'd0);
    add_write(REG_SCALE, '0);
    add_point(1'b0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1, 32'd0);
    // smallest nonzero scale survives only at the peak
    add_write(REG_SCALE, 32'd1);
    add_write(REG_INV_VAR_X, REG_ONE);
    add_point(1'b0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1, 32'd1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    gap_pct     = 18;
    cfg_driving = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (!cfg_driving) quiesce();
        cfg_driving = 1'b1;
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (cfg_driving) cfg_valid <= 1'b0;
        cfg_driving = 1'b0;
        push_item(plan[i].it, plan[i].typed, plan[i].want);
        directed_cnt++;
      end
    end

    // random part: sender gaps at 18%, then 54%, then back to back
    for (ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 18 : (ph == 1) ? 54 : 0;
      for (blk = 0; blk < 4; blk++) begin
        quiesce();
        for (r = REG_SCALE; r <= REG_CENTER_Z; r++) write_reg(3'(r), pick_reg_value(3'(r)));
        if ($urandom_range(2) == 0) write_reg(REG_UNMAPPED, $urandom);
        cfg_valid <= 1'b0;
        repeat (BLOCK_ITEMS) push_item(random_item(), 1'b0, '0);
      end
    end

    // drain; the watchdog bounds the wait
    start <= 1'b0;
    do @(posedge clk); while (pending_density.size() != 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk);

    $display("covered %0d points (%0d directed) across %0d register writes",
             items_taken, directed_cnt, writes_taken);
    $display("checked %0d densities, %0d of them nonzero, %0d mismatches",
             results_seen, nonzero_seen, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
